[design/kav_pkg.sv]
// Shared types, constants and the sequencer microprogram for the altitude/velocity filter.
package kav_pkg;

   typedef enum logic [3:0] {
      OP_END, OP_MUL, OP_DIV, OP_LD, OP_ADD, OP_SUB, OP_MOV,
      OP_BR_NOACC, OP_BR_NOBARO, OP_BR_SMALL
   } op_type;

   typedef enum logic [4:0] {
      SRC_NONE, SRC_DT, SRC_Q, SRC_V, SRC_A, SRC_H, SRC_HH, SRC_HV, SRC_VH, SRC_VV,
      SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_T4, SRC_T5, SRC_T6,
      SRC_PROD, SRC_ACC, SRC_R, SRC_Z, SRC_ONE
   } src_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_H, DST_V, DST_HELD, DST_HH, DST_HV, DST_VH, DST_VV,
      DST_T0, DST_T1, DST_T2, DST_T3, DST_T4, DST_T5, DST_T6
   } dst_type;

   typedef enum logic [2:0] {SH_20, SH_21, SH_24, SH_QHH, SH_QHV, SH_QVV} sh_type;

   typedef logic [6:0] pc_type;

   typedef struct packed {
      op_type  op;
      src_type a;
      src_type b;
      dst_type d;
      sh_type  sh;
      pc_type  tgt;
   } uop_type;

   localparam int      COV_FRAC = 24;
   localparam pc_type  PC_CORR  = 7'd47;
   localparam pc_type  PC_DONE  = 7'd82;

   localparam logic signed [63:0] COV_ONE  = 64'sd16777216;
   localparam logic signed [63:0] EPS_COV  = 64'sd17;
   localparam logic signed [63:0] MAX32    = 64'sd2147483647;
   localparam logic signed [63:0] MIN32    = -64'sd2147483648;
   localparam logic signed [63:0] MAX48    = 64'sd140737488355327;
   localparam logic signed [63:0] MIN48    = -64'sd140737488355328;

   localparam logic [1:0] CSR_ACCEL_NOISE = 2'd0;
   localparam logic [1:0] CSR_BARO_NOISE  = 2'd1;
   localparam logic [1:0] CSR_INIT_HEIGHT = 2'd2;
   localparam logic [1:0] CSR_INIT_VEL    = 2'd3;

   function automatic logic [31:0] sat32(input logic signed [63:0] x);
      if (x > MAX32) return 32'h7fff_ffff;
      else if (x < MIN32) return 32'h8000_0000;
      else return x[31:0];
   endfunction

   function automatic logic ovf32(input logic signed [63:0] x);
      return (x > MAX32) || (x < MIN32);
   endfunction

   function automatic logic [47:0] sat48(input logic signed [63:0] x);
      if (x > MAX48) return 48'h7fff_ffff_ffff;
      else if (x < MIN48) return 48'h8000_0000_0000;
      else return x[47:0];
   endfunction

   function automatic logic ovf48(input logic signed [63:0] x);
      return (x > MAX48) || (x < MIN48);
   endfunction

   function automatic uop_type u_mul(input src_type a, input src_type b, input sh_type sh);
      return '{op: OP_MUL, a: a, b: b, d: DST_NONE, sh: sh, tgt: '0};
   endfunction

   function automatic uop_type u_mov(input src_type a, input dst_type d);
      return '{op: OP_MOV, a: a, b: SRC_NONE, d: d, sh: SH_20, tgt: '0};
   endfunction

   function automatic uop_type u_div(input src_type a, input dst_type d);
      return '{op: OP_DIV, a: a, b: SRC_NONE, d: d, sh: SH_20, tgt: '0};
   endfunction

   function automatic uop_type u_alu(input op_type op, input src_type a);
      return '{op: op, a: a, b: SRC_NONE, d: DST_NONE, sh: SH_20, tgt: '0};
   endfunction

   function automatic uop_type u_br(input op_type op, input pc_type tgt);
      return '{op: op, a: SRC_NONE, b: SRC_NONE, d: DST_NONE, sh: SH_20, tgt: tgt};
   endfunction

   // Microprogram: prediction from 0, correction from PC_CORR, end at PC_DONE.
   function automatic uop_type kav_uop(input pc_type pc);
      unique case (pc)
         7'd0:  return u_br(OP_BR_NOACC, PC_CORR);
         7'd1:  return u_mul(SRC_DT, SRC_DT, SH_20);
         7'd2:  return u_mov(SRC_PROD, DST_T0);          // dt^2
         7'd3:  return u_mul(SRC_T0, SRC_DT, SH_20);
         7'd4:  return u_mov(SRC_PROD, DST_T1);          // dt^3
         7'd5:  return u_mul(SRC_T0, SRC_T0, SH_20);
         7'd6:  return u_mov(SRC_PROD, DST_T2);          // dt^4
         7'd7:  return u_mul(SRC_Q, SRC_T2, SH_QHH);
         7'd8:  return u_mov(SRC_PROD, DST_T3);
         7'd9:  return u_mul(SRC_Q, SRC_T1, SH_QHV);
         7'd10: return u_mov(SRC_PROD, DST_T4);
         7'd11: return u_mul(SRC_Q, SRC_T0, SH_QVV);
         7'd12: return u_mov(SRC_PROD, DST_T5);
         7'd13: return u_mul(SRC_V, SRC_DT, SH_20);
         7'd14: return u_alu(OP_LD, SRC_H);
         7'd15: return u_alu(OP_ADD, SRC_PROD);
         7'd16: return u_mul(SRC_A, SRC_T0, SH_21);
         7'd17: return u_alu(OP_ADD, SRC_PROD);
         7'd18: return u_mov(SRC_ACC, DST_H);
         7'd19: return u_mul(SRC_A, SRC_DT, SH_20);
         7'd20: return u_alu(OP_LD, SRC_V);
         7'd21: return u_alu(OP_ADD, SRC_PROD);
         7'd22: return u_mov(SRC_ACC, DST_V);
         7'd23: return u_alu(OP_LD, SRC_VH);
         7'd24: return u_alu(OP_ADD, SRC_HV);
         7'd25: return u_mov(SRC_ACC, DST_T6);
         7'd26: return u_mul(SRC_DT, SRC_T6, SH_20);
         7'd27: return u_alu(OP_LD, SRC_HH);
         7'd28: return u_alu(OP_ADD, SRC_PROD);
         7'd29: return u_mul(SRC_T0, SRC_VV, SH_20);
         7'd30: return u_alu(OP_ADD, SRC_PROD);
         7'd31: return u_alu(OP_ADD, SRC_T3);
         7'd32: return u_mov(SRC_ACC, DST_HH);
         7'd33: return u_mul(SRC_DT, SRC_VV, SH_20);
         7'd34: return u_mov(SRC_PROD, DST_T6);
         7'd35: return u_alu(OP_LD, SRC_HV);
         7'd36: return u_alu(OP_ADD, SRC_T6);
         7'd37: return u_alu(OP_ADD, SRC_T4);
         7'd38: return u_mov(SRC_ACC, DST_HV);
         7'd39: return u_alu(OP_LD, SRC_VH);
         7'd40: return u_alu(OP_ADD, SRC_T6);
         7'd41: return u_alu(OP_ADD, SRC_T4);
         7'd42: return u_mov(SRC_ACC, DST_VH);
         7'd43: return u_alu(OP_LD, SRC_VV);
         7'd44: return u_alu(OP_ADD, SRC_T5);
         7'd45: return u_mov(SRC_ACC, DST_VV);
         7'd46: return u_mov(SRC_A, DST_HELD);
         7'd47: return u_br(OP_BR_NOBARO, PC_DONE);
         7'd48: return u_alu(OP_LD, SRC_HH);
         7'd49: return u_alu(OP_ADD, SRC_R);
         7'd50: return u_br(OP_BR_SMALL, PC_DONE);
         7'd51: return u_mov(SRC_ACC, DST_T0);           // innovation variance
         7'd52: return u_div(SRC_HH, DST_T1);            // Kh
         7'd53: return u_div(SRC_VH, DST_T2);            // Kv
         7'd54: return u_alu(OP_LD, SRC_Z);
         7'd55: return u_alu(OP_SUB, SRC_H);
         7'd56: return u_mov(SRC_ACC, DST_T3);           // innovation
         7'd57: return u_mul(SRC_T1, SRC_T3, SH_24);
         7'd58: return u_alu(OP_LD, SRC_H);
         7'd59: return u_alu(OP_ADD, SRC_PROD);
         7'd60: return u_mov(SRC_ACC, DST_H);
         7'd61: return u_mul(SRC_T2, SRC_T3, SH_24);
         7'd62: return u_alu(OP_LD, SRC_V);
         7'd63: return u_alu(OP_ADD, SRC_PROD);
         7'd64: return u_mov(SRC_ACC, DST_V);
         7'd65: return u_mov(SRC_HH, DST_T4);
         7'd66: return u_mov(SRC_HV, DST_T5);
         7'd67: return u_alu(OP_LD, SRC_ONE);
         7'd68: return u_alu(OP_SUB, SRC_T1);
         7'd69: return u_mov(SRC_ACC, DST_T6);
         7'd70: return u_mul(SRC_T6, SRC_T4, SH_24);
         7'd71: return u_mov(SRC_PROD, DST_HH);
         7'd72: return u_mul(SRC_T6, SRC_T5, SH_24);
         7'd73: return u_mov(SRC_PROD, DST_HV);
         7'd74: return u_mul(SRC_T2, SRC_T4, SH_24);
         7'd75: return u_alu(OP_LD, SRC_VH);
         7'd76: return u_alu(OP_SUB, SRC_PROD);
         7'd77: return u_mov(SRC_ACC, DST_VH);
         7'd78: return u_mul(SRC_T2, SRC_T5, SH_24);
         7'd79: return u_alu(OP_LD, SRC_VV);
         7'd80: return u_alu(OP_SUB, SRC_PROD);
         7'd81: return u_mov(SRC_ACC, DST_VV);
         default: return u_br(OP_END, PC_DONE);
      endcase
   endfunction

endpackage

[design/kav_req_if.sv]
// Request channel: one filter step per transaction.
interface kav_req_if;
   logic               valid;
   logic               ready;
   logic               restart;
   logic               accel_valid;
   logic signed [31:0] vert_accel;
   logic        [23:0] time_step;
   logic               baro_valid;
   logic signed [31:0] baro_altitude;

   modport source(output valid, restart, accel_valid, vert_accel, time_step, baro_valid,
                  baro_altitude, input ready);
   modport sink(input valid, restart, accel_valid, vert_accel, time_step, baro_valid,
                baro_altitude, output ready);
endinterface

[design/kav_rsp_if.sv]
// Response channel: filter estimate after each step.
interface kav_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] height;
   logic signed [31:0] velocity;
   logic signed [31:0] last_accel;
   logic               baro_skipped;
   logic               saturated;

   modport source(output valid, height, velocity, last_accel, baro_skipped, saturated,
                  input ready);
   modport sink(input valid, height, velocity, last_accel, baro_skipped, saturated,
                output ready);
endinterface

[design/altitude_velocity_kalman.sv]
// Every multiply runs on the one shared 52x13 multiplier (12 per prediction, 6 per correction);
// each of the two gain divisions runs on the serial divider.
// Throughput: one item at a time, next request taken from the cycle after the response is loaded;
// a new request is taken while the last response is pending.
// Reset: synchronous; estimates, held accel and off-diagonal covariance clear, diagonal to 1.0.
module altitude_velocity_kalman #(
   parameter int STATE_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   kav_req_if.sink     req_ch,
   kav_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import kav_pkg::*;

   localparam int R_SHIFT = COV_FRAC - STATE_FRAC_BITS;

   typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_WMUL, ST_WDIV, ST_DONE} state_type;

   state_type          state_ff;
   pc_type             pc_ff;
   logic [31:0]        qvar_ff, rvar_ff;
   logic signed [31:0] init_h_ff, init_v_ff;
   logic               accel_en_ff, baro_en_ff;
   logic signed [31:0] a_ff, z_ff;
   logic [23:0]        dt_ff;
   logic signed [31:0] h_ff, v_ff, held_ff;
   logic signed [47:0] hh_ff, hv_ff, vh_ff, vv_ff;
   logic signed [63:0] t0_ff, t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff;
   logic signed [63:0] acc_ff, prod_ff;
   logic               skip_ff, sat_ff;
   logic               rsp_valid_ff, rsp_skip_ff, rsp_sat_ff;
   logic signed [31:0] rsp_h_ff, rsp_v_ff, rsp_a_ff;
   dst_type            div_dst_ff;

   uop_type            uop;
   logic signed [63:0] mux_a, mux_b;
   logic [5:0]         mul_shift;
   logic               mul_start, mul_done, mul_sat;
   logic signed [63:0] mul_res;
   logic               div_start, div_done, div_sat;
   logic signed [47:0] div_q;

   assign uop = kav_uop(pc_ff);

   always_comb begin
      unique case (uop.a)
         SRC_DT:   mux_a = 64'(dt_ff);
         SRC_Q:    mux_a = 64'(qvar_ff);
         SRC_V:    mux_a = 64'(v_ff);
         SRC_A:    mux_a = 64'(a_ff);
         SRC_H:    mux_a = 64'(h_ff);
         SRC_HH:   mux_a = 64'(hh_ff);
         SRC_HV:   mux_a = 64'(hv_ff);
         SRC_VH:   mux_a = 64'(vh_ff);
         SRC_VV:   mux_a = 64'(vv_ff);
         SRC_T0:   mux_a = t0_ff;
         SRC_T1:   mux_a = t1_ff;
         SRC_T2:   mux_a = t2_ff;
         SRC_T3:   mux_a = t3_ff;
         SRC_T4:   mux_a = t4_ff;
         SRC_T5:   mux_a = t5_ff;
         SRC_T6:   mux_a = t6_ff;
         SRC_PROD: mux_a = prod_ff;
         SRC_ACC:  mux_a = acc_ff;
         SRC_R:    mux_a = 64'(rvar_ff) << R_SHIFT;
         SRC_Z:    mux_a = 64'(z_ff);
         SRC_ONE:  mux_a = COV_ONE;
         default:  mux_a = '0;
      endcase
      unique case (uop.b)
         SRC_DT:  mux_b = 64'(dt_ff);
         SRC_VV:  mux_b = 64'(vv_ff);
         SRC_T0:  mux_b = t0_ff;
         SRC_T1:  mux_b = t1_ff;
         SRC_T2:  mux_b = t2_ff;
         SRC_T3:  mux_b = t3_ff;
         SRC_T4:  mux_b = t4_ff;
         SRC_T5:  mux_b = t5_ff;
         SRC_T6:  mux_b = t6_ff;
         default: mux_b = '0;
      endcase
      unique case (uop.sh)
         SH_20:   mul_shift = 6'd20;
         SH_21:   mul_shift = 6'd21;
         SH_24:   mul_shift = 6'(COV_FRAC);
         SH_QHH:  mul_shift = 6'(STATE_FRAC_BITS - 2);
         SH_QHV:  mul_shift = 6'(STATE_FRAC_BITS - 3);
         SH_QVV:  mul_shift = 6'(STATE_FRAC_BITS - 4);
         default: mul_shift = 6'd20;
      endcase
   end

   assign mul_start = (state_ff == ST_RUN) && (uop.op == OP_MUL);
   assign div_start = (state_ff == ST_RUN) && (uop.op == OP_DIV);

   kav_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mux_a),
      .op_b   (mux_b),
      .shift  (mul_shift),
      .done   (mul_done),
      .result (mul_res),
      .sat    (mul_sat)
   );

   kav_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (mux_a[47:0]),
      .den   (t0_ff[48:0]),
      .done  (div_done),
      .quot  (div_q),
      .sat   (div_sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         qvar_ff      <= 32'h0001_0000;
         rvar_ff      <= 32'h0001_0000;
         init_h_ff    <= '0;
         init_v_ff    <= '0;
         h_ff         <= '0;
         v_ff         <= '0;
         held_ff      <= '0;
         hh_ff        <= 48'(COV_ONE);
         hv_ff        <= '0;
         vh_ff        <= '0;
         vv_ff        <= 48'(COV_ONE);
         skip_ff      <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ACCEL_NOISE: qvar_ff   <= csr_wdata;
               CSR_BARO_NOISE:  rvar_ff   <= csr_wdata;
               CSR_INIT_HEIGHT: init_h_ff <= csr_wdata;
               CSR_INIT_VEL:    init_v_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ch.ready) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  accel_en_ff <= req_ch.accel_valid;
                  baro_en_ff  <= req_ch.baro_valid;
                  a_ff        <= req_ch.vert_accel;
                  dt_ff       <= req_ch.time_step;
                  z_ff        <= req_ch.baro_altitude;
                  skip_ff     <= 1'b0;
                  sat_ff      <= 1'b0;
                  pc_ff       <= '0;
                  state_ff    <= ST_RUN;
                  if (req_ch.restart) begin
                     h_ff    <= init_h_ff;
                     v_ff    <= init_v_ff;
                     held_ff <= '0;
                     hh_ff   <= 48'(COV_ONE);
                     hv_ff   <= '0;
                     vh_ff   <= '0;
                     vv_ff   <= 48'(COV_ONE);
                  end
               end
            end
            ST_RUN: begin
               pc_ff <= pc_ff + 7'd1;
               unique case (uop.op)
                  OP_MUL: state_ff <= ST_WMUL;
                  OP_DIV: begin
                     // pc has already moved on when the quotient arrives; remember where the gain goes
                     div_dst_ff <= uop.d;
                     state_ff   <= ST_WDIV;
                  end
                  OP_LD:  acc_ff <= mux_a;
                  OP_ADD: acc_ff <= acc_ff + mux_a;
                  OP_SUB: acc_ff <= acc_ff - mux_a;
                  OP_MOV: begin
                     unique case (uop.d)
                        DST_H: begin
                           h_ff <= sat32(mux_a);
                           if (ovf32(mux_a)) sat_ff <= 1'b1;
                        end
                        DST_V: begin
                           v_ff <= sat32(mux_a);
                           if (ovf32(mux_a)) sat_ff <= 1'b1;
                        end
                        DST_HELD: held_ff <= mux_a[31:0];
                        DST_HH: begin
                           hh_ff <= sat48(mux_a);
                           if (ovf48(mux_a)) sat_ff <= 1'b1;
                        end
                        DST_HV: begin
                           hv_ff <= sat48(mux_a);
                           if (ovf48(mux_a)) sat_ff <= 1'b1;
                        end
                        DST_VH: begin
                           vh_ff <= sat48(mux_a);
                           if (ovf48(mux_a)) sat_ff <= 1'b1;
                        end
                        DST_VV: begin
                           vv_ff <= sat48(mux_a);
                           if (ovf48(mux_a)) sat_ff <= 1'b1;
                        end
                        DST_T0: t0_ff <= mux_a;
                        DST_T1: t1_ff <= mux_a;
                        DST_T2: t2_ff <= mux_a;
                        DST_T3: t3_ff <= mux_a;
                        DST_T4: t4_ff <= mux_a;
                        DST_T5: t5_ff <= mux_a;
                        DST_T6: t6_ff <= mux_a;
                        default: ;
                     endcase
                  end
                  OP_BR_NOACC: begin
                     if (!accel_en_ff) pc_ff <= uop.tgt;
                  end
                  OP_BR_NOBARO: begin
                     if (!baro_en_ff) pc_ff <= uop.tgt;
                  end
                  OP_BR_SMALL: begin
                     // innovation variance below epsilon: leave state untouched
                     if (acc_ff < EPS_COV) begin
                        skip_ff <= 1'b1;
                        pc_ff   <= uop.tgt;
                     end
                  end
                  default: state_ff <= ST_DONE;
               endcase
            end
            ST_WMUL: begin
               if (mul_done) begin
                  prod_ff  <= mul_res;
                  if (mul_sat) sat_ff <= 1'b1;
                  state_ff <= ST_RUN;
               end
            end
            ST_WDIV: begin
               if (div_done) begin
                  if (div_dst_ff == DST_T1) t1_ff <= 64'(div_q);
                  else t2_ff <= 64'(div_q);
                  if (div_sat) sat_ff <= 1'b1;
                  state_ff <= ST_RUN;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_h_ff     <= h_ff;
                  rsp_v_ff     <= v_ff;
                  rsp_a_ff     <= held_ff;
                  rsp_skip_ff  <= skip_ff;
                  rsp_sat_ff   <= sat_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.height       = rsp_h_ff;
   assign rsp_ch.velocity     = rsp_v_ff;
   assign rsp_ch.last_accel   = rsp_a_ff;
   assign rsp_ch.baro_skipped = rsp_skip_ff;
   assign rsp_ch.saturated    = rsp_sat_ff;
endmodule

[design/kav_mul.sv]
// Shared multiplier: 13-bit digit per cycle, then round half away from zero and clip.
module kav_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] op_a,
   input  logic signed [63:0] op_b,
   input  logic        [5:0]  shift,
   output logic               done,
   output logic signed [63:0] result,
   output logic               sat
);
   import kav_pkg::*;

   localparam int MAG_W  = 52;
   localparam int DIG_W  = 13;
   localparam int ACC_W  = 2 * MAG_W;
   localparam logic [ACC_W:0] PROD_LIM = (ACC_W + 1)'(1) << 60;

   typedef enum logic [1:0] {M_IDLE, M_ACCUM, M_ROUND} mstate_type;

   mstate_type             state_ff;
   logic [MAG_W-1:0]       a_mag_ff, b_sh_ff;
   logic [ACC_W-1:0]       acc_ff;
   logic                   neg_ff;
   logic [5:0]             shift_ff;
   logic [1:0]             cnt_ff;
   logic                   done_ff, sat_ff;
   logic signed [63:0]     result_ff;

   logic [63:0]            a_abs, b_abs;
   logic [ACC_W-1:0]       acc_in;
   logic [ACC_W:0]         rsum, quo;
   logic [60:0]            mag;
   logic                   over;

   always_comb begin
      a_abs  = op_a[63] ? 64'(-op_a) : 64'(op_a);
      b_abs  = op_b[63] ? 64'(-op_b) : 64'(op_b);
      acc_in = {acc_ff[ACC_W-DIG_W-1:0], {DIG_W{1'b0}}}
             + ACC_W'(a_mag_ff * b_sh_ff[MAG_W-1 -: DIG_W]);
      rsum   = {1'b0, acc_ff} + ((ACC_W + 1)'(1) << (shift_ff - 6'd1));
      quo    = rsum >> shift_ff;
      over   = quo > PROD_LIM;
      mag    = over ? PROD_LIM[60:0] : quo[60:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            M_IDLE: begin
               if (start) begin
                  a_mag_ff <= a_abs[MAG_W-1:0];
                  b_sh_ff  <= b_abs[MAG_W-1:0];
                  neg_ff   <= op_a[63] ^ op_b[63];
                  shift_ff <= shift;
                  acc_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= M_ACCUM;
               end
            end
            M_ACCUM: begin
               acc_ff  <= acc_in;
               b_sh_ff <= {b_sh_ff[MAG_W-DIG_W-1:0], {DIG_W{1'b0}}};
               cnt_ff  <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) state_ff <= M_ROUND;
            end
            M_ROUND: begin
               result_ff <= neg_ff ? -64'(mag) : 64'(mag);
               sat_ff    <= over;
               done_ff   <= 1'b1;
               state_ff  <= M_IDLE;
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;
   assign sat    = sat_ff;
endmodule

[design/kav_div.sv]
// Serial restoring divider for the Kalman gain: signed Q24.24 quotient, rounded and clipped.
module kav_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [47:0] num,
   input  logic        [48:0] den,
   output logic               done,
   output logic signed [47:0] quot,
   output logic               sat
);
   import kav_pkg::*;

   localparam int DVD_W = 48 + COV_FRAC;
   localparam logic [DVD_W-1:0] POS_LIM = DVD_W'(48'h7fff_ffff_ffff);
   localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(49'h0_8000_0000_0000);

   typedef enum logic [1:0] {D_IDLE, D_SHIFT, D_FIN} dstate_type;

   dstate_type         state_ff;
   logic [DVD_W-1:0]   dvd_ff;
   logic [48:0]        rem_ff, den_ff;
   logic               neg_ff;
   logic [6:0]         cnt_ff;
   logic               done_ff, sat_ff;
   logic signed [47:0] quot_ff;

   logic [47:0]        num_mag;
   logic [49:0]        trial;
   logic               ge;
   logic [DVD_W-1:0]   qr;

   always_comb begin
      num_mag = num[47] ? 48'(-num) : 48'(num);
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      ge      = trial >= {1'b0, den_ff};
      qr      = dvd_ff + DVD_W'({rem_ff, 1'b0} >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  neg_ff   <= num[47];
                  dvd_ff   <= {num_mag, {COV_FRAC{1'b0}}};
                  rem_ff   <= '0;
                  den_ff   <= den;
                  cnt_ff   <= '0;
                  state_ff <= D_SHIFT;
               end
            end
            D_SHIFT: begin
               rem_ff <= ge ? 49'(trial - {1'b0, den_ff}) : trial[48:0];
               dvd_ff <= {dvd_ff[DVD_W-2:0], ge};
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(DVD_W - 1)) state_ff <= D_FIN;
            end
            D_FIN: begin
               if (!neg_ff) begin
                  sat_ff  <= qr > POS_LIM;
                  quot_ff <= (qr > POS_LIM) ? POS_LIM[47:0] : qr[47:0];
               end else begin
                  sat_ff  <= qr > NEG_LIM;
                  quot_ff <= (qr > NEG_LIM) ? 48'h8000_0000_0000 : 48'(-qr);
               end
               done_ff  <= 1'b1;
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign sat  = sat_ff;
endmodule

[tb/sv/altitude_velocity_kalman_checker.sv]
// Checker for the altitude/velocity filter: fixed-point predictor and response scoreboard.
`timescale 1ns / 100ps
module altitude_velocity_kalman_checker (
   input  logic        clock,
   input  logic        reset,
   kav_req_if          req_mon,
   kav_rsp_if          rsp_mon,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   import kav_pkg::*;

   localparam int FRAC = 16;
   localparam logic [127:0] PROD_MAX = 128'd1 << 60;

   typedef struct packed {
      logic signed [31:0] height;
      logic signed [31:0] velocity;
      logic signed [31:0] last_accel;
      logic               baro_skipped;
      logic               saturated;
   } estimate_type;

   estimate_type estimate_q[$];

   logic [31:0] q_noise, r_noise, init_h, init_v;
   longint h, v, a_held, phh, phv, pvh, pvv;
   bit clipped;

   function automatic longint clip(longint x, int w);
      longint hi, lo;
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) begin
         clipped = 1;
         return hi;
      end
      if (x < lo) begin
         clipped = 1;
         return lo;
      end
      return x;
   endfunction

   // round(a*b / 2^s), ties away from zero, magnitude limited to 2^60
   function automatic longint mul_round(longint a, longint b, int s);
      logic [63:0]  ua, ub;
      logic [127:0] p;
      bit neg;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = {64'd0, ua} * {64'd0, ub};
      p = (p + (128'd1 << (s - 1))) >> s;
      if (p > PROD_MAX) begin
         clipped = 1;
         p = PROD_MAX;
      end
      return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
   endfunction

   // p/s in Q24.24, rounded half up on the magnitude
   function automatic longint kalman_gain(longint p, longint s);
      logic [63:0]  up;
      logic [127:0] num, q, r;
      bit neg;
      neg = p < 0;
      up = neg ? -p : p;
      q = {64'd0, up} / s;
      if (q > ((128'd1 << 47) - 1)) begin
         clipped = 1;
         q = 128'd1 << 47;
      end else begin
         num = {64'd0, up} << COV_FRAC;
         q = num / s;
         r = num % s;
         if ((r << 1) >= s) q = q + 1;
      end
      return clip(neg ? -$signed(q[63:0]) : $signed(q[63:0]), 48);
   endfunction

   function automatic void filter_restart();
      h = $signed(init_h);
      v = $signed(init_v);
      a_held = 0;
      phh = COV_ONE; phv = 0; pvh = 0; pvv = COV_ONE;
   endfunction

   function automatic void filter_predict(longint a, longint dt);
      longint q, dt2, dt3, dt4, qhh, qhv, qvv, nhh, nhv, nvh, nvv;
      q = longint'(q_noise);
      dt2 = mul_round(dt, dt, 20);
      dt3 = mul_round(dt2, dt, 20);
      dt4 = mul_round(dt2, dt2, 20);
      qhh = mul_round(q, dt4, FRAC - 2);
      qhv = mul_round(q, dt3, FRAC - 3);
      qvv = mul_round(q, dt2, FRAC - 4);
      h = clip(h + mul_round(v, dt, 20) + mul_round(a, dt2, 21), 32);
      v = clip(v + mul_round(a, dt, 20), 32);
      nhh = phh + mul_round(dt, pvh + phv, 20) + mul_round(dt2, pvv, 20) + qhh;
      nhv = phv + mul_round(dt, pvv, 20) + qhv;
      nvh = pvh + mul_round(dt, pvv, 20) + qhv;
      nvv = pvv + qvv;
      phh = clip(nhh, 48); phv = clip(nhv, 48);
      pvh = clip(nvh, 48); pvv = clip(nvv, 48);
      a_held = a;
   endfunction

   // returns 1 when the innovation variance is too small to correct
   function automatic bit filter_correct(longint z);
      longint s, kh, kv, e, ohh, ohv;
      s = phh + (longint'(r_noise) <<< (COV_FRAC - FRAC));
      if (s < EPS_COV) return 1;
      kh = kalman_gain(phh, s);
      kv = kalman_gain(pvh, s);
      e = z - h;
      h = clip(h + mul_round(kh, e, COV_FRAC), 32);
      v = clip(v + mul_round(kv, e, COV_FRAC), 32);
      ohh = phh; ohv = phv;
      phh = clip(mul_round(COV_ONE - kh, ohh, COV_FRAC), 48);
      phv = clip(mul_round(COV_ONE - kh, ohv, COV_FRAC), 48);
      pvh = clip(pvh - mul_round(kv, ohh, COV_FRAC), 48);
      pvv = clip(pvv - mul_round(kv, ohv, COV_FRAC), 48);
      return 0;
   endfunction

   function automatic estimate_type filter_step();
      estimate_type e;
      bit skip;
      skip = 0;
      clipped = 0;
      if (req_mon.restart) filter_restart();
      if (req_mon.accel_valid)
         filter_predict(longint'(req_mon.vert_accel), longint'({8'd0, req_mon.time_step}));
      if (req_mon.baro_valid) skip = filter_correct(longint'(req_mon.baro_altitude));
      e.height = h[31:0];
      e.velocity = v[31:0];
      e.last_accel = a_held[31:0];
      e.baro_skipped = skip;
      e.saturated = clipped;
      return e;
   endfunction

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch in %s: got %h, expected %h", $realtime, field, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;
   assign pending = estimate_q.size();

   always @(posedge clock) begin
      estimate_type want;
      if (reset) begin
         q_noise = 32'd65536; r_noise = 32'd65536; init_h = 0; init_v = 0;
         h = 0; v = 0; a_held = 0;
         phh = COV_ONE; phv = 0; pvh = 0; pvv = COV_ONE;
         estimate_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ACCEL_NOISE: q_noise = csr_wdata;
               CSR_BARO_NOISE:  r_noise = csr_wdata;
               CSR_INIT_HEIGHT: init_h = csr_wdata;
               CSR_INIT_VEL:    init_v = csr_wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) estimate_q.push_back(filter_step());
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (estimate_q.size() == 0) begin
               report("unexpected transaction", rsp_mon.height, 32'h0);
            end else begin
               want = estimate_q.pop_front();
               if (rsp_mon.height !== want.height)
                  report("height", rsp_mon.height, want.height);
               if (rsp_mon.velocity !== want.velocity)
                  report("velocity", rsp_mon.velocity, want.velocity);
               if (rsp_mon.last_accel !== want.last_accel)
                  report("last_accel", rsp_mon.last_accel, want.last_accel);
               if (rsp_mon.baro_skipped !== want.baro_skipped)
                  report("baro_skipped", 32'(rsp_mon.baro_skipped), 32'(want.baro_skipped));
               if (rsp_mon.saturated !== want.saturated)
                  report("saturated", 32'(rsp_mon.saturated), 32'(want.saturated));
            end
         end
      end
   end

endmodule

[tb/sv/altitude_velocity_kalman_tb.sv]
// Top of the altitude/velocity filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module altitude_velocity_kalman_tb;
   import kav_pkg::*;

   typedef struct {
      bit                 restart;
      bit                 accel_valid;
      logic signed [31:0] accel;
      logic        [23:0] dt;
      bit                 baro_valid;
      logic signed [31:0] alt;
   } filter_step_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;
   int          fail_count;
   int          pending;
   int          req_idle_pct;
   int          rsp_idle_pct;
   bit          hold_rsp;

   kav_req_if req_ch();
   kav_rsp_if rsp_ch();

   altitude_velocity_kalman u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   altitude_velocity_kalman_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #50_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response side: random stalls, or one long hold-off when asked
   initial begin
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 0;
            repeat (600) @(negedge clock);
            hold_rsp = 0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic filter_step_type mk(bit rs, bit av, logic [31:0] a, logic [23:0] dt,
                                          bit bv, logic [31:0] z);
      filter_step_type s;
      s.restart = rs; s.accel_valid = av; s.accel = a; s.dt = dt;
      s.baro_valid = bv; s.alt = z;
      return s;
   endfunction

   function automatic filter_step_type random_step();
      filter_step_type s;
      if ($urandom_range(99) < 10)
         return mk(1'($urandom), 1'($urandom), $urandom, 24'($urandom), 1'($urandom),
                   $urandom);
      s.restart = $urandom_range(99) < 3;
      s.accel_valid = $urandom_range(99) < 85;
      s.dt = ($urandom_range(99) < 5) ? 24'($urandom) : 24'($urandom_range(0, 32768));
      s.accel = ($urandom_range(99) < 5) ? $urandom
                : $signed($urandom_range(0, 40 << 16)) - (20 <<< 16);
      s.baro_valid = $urandom_range(99) < 60;
      s.alt = ($urandom_range(99) < 5) ? $urandom
              : $signed($urandom_range(0, 1000 << 16)) - (500 <<< 16);
      return s;
   endfunction

   task automatic send(filter_step_type s);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 0;
         @(negedge clock);
      end
      req_ch.valid         <= 1;
      req_ch.restart       <= s.restart;
      req_ch.accel_valid   <= s.accel_valid;
      req_ch.vert_accel    <= s.accel;
      req_ch.time_step     <= s.dt;
      req_ch.baro_valid    <= s.baro_valid;
      req_ch.baro_altitude <= s.alt;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] data);
      csr_we <= 1; csr_index <= idx; csr_wdata <= data;
      @(negedge clock);
      csr_we <= 0;
   endtask

   // block is drained before any register write
   task automatic drain();
      req_ch.valid <= 0;
      wait (pending == 0);
      repeat (400) @(negedge clock);
   endtask

   initial begin
      req_ch.valid = 0; req_ch.restart = 0; req_ch.accel_valid = 0;
      req_ch.vert_accel = 0; req_ch.time_step = 0; req_ch.baro_valid = 0;
      req_ch.baro_altitude = 0;
      csr_we = 0; csr_index = CSR_ACCEL_NOISE; csr_wdata = 0;
      hold_rsp = 0; req_idle_pct = 28; rsp_idle_pct = 82;
      reset = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty item, restart, extreme steps, tiny innovation variance
      send(mk(0, 0, 0, 0, 0, 0));
      send(mk(0, 0, 0, 0, 1, 32'sd100 <<< 16));
      send(mk(1, 0, 0, 0, 0, 0));
      send(mk(0, 1, 32'sd9 <<< 16, 24'd104858, 0, 0));
      send(mk(0, 1, 32'sd9 <<< 16, 24'd104858, 1, 32'sd1 <<< 16));
      send(mk(0, 1, 32'h7fff_ffff, 24'hff_ffff, 0, 0));
      send(mk(0, 1, 32'h8000_0000, 24'hff_ffff, 1, 32'h8000_0000));
      send(mk(0, 1, 0, 0, 1, 32'h7fff_ffff));
      send(mk(1, 1, 32'h8000_0000, 24'd1, 1, 32'h7fff_ffff));
      send(mk(1, 1, 32'hffff_ffff, 24'h10_0000, 1, 32'hffff_ffff));
      drain();
      csr_write(CSR_BARO_NOISE, 32'd0);
      csr_write(CSR_ACCEL_NOISE, 32'd0);
      csr_write(CSR_INIT_HEIGHT, 32'h7fff_ffff);
      csr_write(CSR_INIT_VEL, 32'h8000_0000);
      // zero noise: first correction drives the height variance to zero, second is skipped
      send(mk(1, 0, 0, 0, 1, 32'sd5 <<< 16));
      send(mk(0, 0, 0, 0, 1, 32'sd7 <<< 16));
      send(mk(0, 1, 32'sd1 <<< 16, 24'd0, 1, 0));
      send(mk(1, 1, 32'sd3 <<< 16, 24'd5000, 1, 0));
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               csr_write(CSR_ACCEL_NOISE, 32'd65536); csr_write(CSR_BARO_NOISE, 32'd65536);
               csr_write(CSR_INIT_HEIGHT, 32'd0); csr_write(CSR_INIT_VEL, 32'd0);
            end
            1: begin
               csr_write(CSR_ACCEL_NOISE, 32'hffff_ffff); csr_write(CSR_BARO_NOISE, 32'd0);
               csr_write(CSR_INIT_HEIGHT, 32'h8000_0000); csr_write(CSR_INIT_VEL, 32'h7fff_ffff);
            end
            2: begin
               req_idle_pct = 82; rsp_idle_pct = 28;
               csr_write(CSR_ACCEL_NOISE, 32'd0); csr_write(CSR_BARO_NOISE, 32'hffff_ffff);
               csr_write(CSR_INIT_HEIGHT, 32'sd200 <<< 16); csr_write(CSR_INIT_VEL, -32'sd3 <<< 16);
            end
            default: begin
               req_idle_pct = 0; rsp_idle_pct = 0;
               csr_write(CSR_ACCEL_NOISE, $urandom_range(0, 4 << 16));
               csr_write(CSR_BARO_NOISE, $urandom_range(0, 4 << 16));
               csr_write(CSR_INIT_HEIGHT, $urandom); csr_write(CSR_INIT_VEL, $urandom);
            end
         endcase
         send(mk(1, 0, 0, 0, 0, 0));
         for (int i = 0; i < 485; i++) begin
            if (phase == 1 && i == 100) hold_rsp = 1;
            if (phase == 2 && i == 200) begin
               req_ch.valid <= 0;
               wait (pending == 0);
               @(negedge clock);
            end
            send(random_step());
         end
         drain();
      end

      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
